@@ hdl/rtp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package rtp_pkg;

	localparam int unsigned CFG_IDX_W  = 8;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned CAP_W      = 16;
	localparam int unsigned TPM_W      = 18;
	localparam int unsigned OPS_W      = 8;
	localparam int unsigned WARM_W     = 8;
	localparam int unsigned WORD_W     = 32;
	localparam int unsigned HOUR_W     = 5;
	localparam int unsigned MIN_W      = 6;
	localparam int unsigned SEC_W      = 6;
	localparam int unsigned DIV_CNT_W  = $clog2(WORD_W);

	localparam logic [CAP_W-1:0]  TIMER_PERIOD_RST = 16'hFFFF;
	localparam logic [TPM_W-1:0]  TICKS_PER_MS_RST = 18'd1000;
	localparam logic [OPS_W-1:0]  OVF_PER_SEC_RST  = 8'd15;
	localparam logic [WARM_W-1:0] WARMUP_RST       = 8'd5;
	localparam logic [WORD_W-1:0] PERIOD_MS_RST    = 32'd100;

	localparam logic [SEC_W-1:0]  SEC_WRAP  = 6'd60;
	localparam logic [MIN_W-1:0]  MIN_WRAP  = 6'd60;
	localparam logic [HOUR_W-1:0] HOUR_WRAP = 5'd24;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TIMER_PERIOD = 8'd0,
		CFG_TICKS_PER_MS = 8'd1,
		CFG_OVF_PER_SEC  = 8'd2,
		CFG_WARMUP       = 8'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic accept;
		logic div_load;
		logic div_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic pair;
		logic div_last;
	} sts_t;

endpackage
`default_nettype wire

@@ hdl/rtp_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface rtp_in_if;
	logic                            valid;
	logic                            ready;
	logic                            action;
	logic [rtp_pkg::CAP_W-1:0]       capture_value;

	modport source (output valid, action, capture_value, input ready);
	modport sink (input valid, action, capture_value, output ready);
endinterface
`default_nettype wire

@@ hdl/rtp_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface rtp_out_if;
	logic                         valid;
	logic                         ready;
	logic [rtp_pkg::WORD_W-1:0]   interval_ms;
	logic [rtp_pkg::WORD_W-1:0]   elapsed_seconds;
	logic [rtp_pkg::HOUR_W-1:0]   clock_hours;
	logic [rtp_pkg::MIN_W-1:0]    clock_minutes;
	logic [rtp_pkg::SEC_W-1:0]    clock_seconds;
	logic                         round_done;
	logic                         locked;
	logic [rtp_pkg::WORD_W-1:0]   round_count;

	modport source (output valid, interval_ms, elapsed_seconds, clock_hours, clock_minutes,
		clock_seconds, round_done, locked, round_count, input ready);
	modport sink (input valid, interval_ms, elapsed_seconds, clock_hours, clock_minutes,
		clock_seconds, round_done, locked, round_count, output ready);
endinterface
`default_nettype wire

@@ hdl/rtp_cfg_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface rtp_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [rtp_pkg::CFG_IDX_W-1:0]    index;
	logic [rtp_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ hdl/rtp_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module rtp_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	input  wire rtp_pkg::sts_t sts,
	output rtp_pkg::cmd_t      cmd
);

	rtp_pkg::state_t state_q;
	rtp_pkg::state_t state_nxt;
	logic            out_valid_q;
	logic            out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			rtp_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_nxt = sts.pair ? rtp_pkg::ST_LOAD : rtp_pkg::ST_OUT;
				end
			end
			rtp_pkg::ST_LOAD: begin
				state_nxt = rtp_pkg::ST_DIV;
			end
			rtp_pkg::ST_DIV: begin
				if (sts.div_last) begin
					state_nxt = rtp_pkg::ST_OUT;
				end
			end
			rtp_pkg::ST_OUT: begin
				if (out_free) begin
					state_nxt = rtp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = rtp_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			rtp_pkg::ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			rtp_pkg::ST_LOAD: begin
				cmd.div_load = 1'b1;
			end
			rtp_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
			end
			rtp_pkg::ST_OUT: begin
				cmd.out_load = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rtp_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

@@ hdl/rtp_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
module rtp_dp (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire rtp_pkg::cmd_t                  cmd,
	output rtp_pkg::sts_t                       sts,
	input  wire logic                           cfg_we,
	input  wire logic [rtp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [rtp_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           in_action,
	input  wire logic [rtp_pkg::CAP_W-1:0]      in_capture_value,
	output logic [rtp_pkg::WORD_W-1:0]          interval_ms,
	output logic [rtp_pkg::WORD_W-1:0]          elapsed_seconds,
	output logic [rtp_pkg::HOUR_W-1:0]          clock_hours,
	output logic [rtp_pkg::MIN_W-1:0]           clock_minutes,
	output logic [rtp_pkg::SEC_W-1:0]           clock_seconds,
	output logic                                round_done,
	output logic                                locked,
	output logic [rtp_pkg::WORD_W-1:0]          round_count
);

	localparam int unsigned MUL_B_W = rtp_pkg::CAP_W + 1;
	localparam int unsigned PROD_W  = rtp_pkg::WORD_W + MUL_B_W;

	// configuration
	logic [rtp_pkg::CAP_W-1:0]  timer_period_q;
	logic [rtp_pkg::TPM_W-1:0]  ticks_per_ms_q;
	logic [rtp_pkg::OPS_W-1:0]  ovf_per_sec_q;
	logic [rtp_pkg::WARM_W-1:0] warmup_q;

	// block state
	logic [rtp_pkg::WORD_W-1:0] ovf_cnt_q;
	logic [rtp_pkg::OPS_W-1:0]  phase_q;
	logic                       first_taken_q;
	logic [rtp_pkg::CAP_W-1:0]  first_cap_q;
	logic                       lock_q;
	logic [rtp_pkg::WORD_W-1:0] rounds_q;
	logic [rtp_pkg::WORD_W-1:0] period_q;
	logic [rtp_pkg::WORD_W-1:0] secs_q;
	logic [rtp_pkg::HOUR_W-1:0] hour_q;
	logic [rtp_pkg::MIN_W-1:0]  min_q;
	logic [rtp_pkg::SEC_W-1:0]  sec_q;
	logic                       done_q;

	// pair measurement
	logic [rtp_pkg::WORD_W-1:0]    prod_s1;
	logic [rtp_pkg::CAP_W-1:0]     cap_s1;
	logic [rtp_pkg::WORD_W-1:0]    quo_q;
	logic [rtp_pkg::TPM_W-1:0]     rem_q;
	logic [rtp_pkg::DIV_CNT_W-1:0] div_cnt_q;

	logic [PROD_W-1:0]          prod_full;
	logic [rtp_pkg::WORD_W-1:0] diff;
	logic [rtp_pkg::TPM_W:0]    rem_shift;
	logic [rtp_pkg::TPM_W:0]    rem_trial;
	logic                       quo_bit;
	logic [rtp_pkg::OPS_W-1:0]  phase_inc;
	logic                       boundary;
	logic [rtp_pkg::WORD_W-1:0] rounds_inc;
	logic [rtp_pkg::SEC_W-1:0]  sec_nxt;
	logic [rtp_pkg::MIN_W-1:0]  min_nxt;
	logic [rtp_pkg::HOUR_W-1:0] hour_nxt;

	assign sts.pair     = in_action && lock_q && first_taken_q;
	assign sts.div_last = (div_cnt_q == rtp_pkg::DIV_CNT_W'(rtp_pkg::WORD_W - 1));

	assign prod_full = ovf_cnt_q * ({1'b0, timer_period_q} + MUL_B_W'(1));
	assign diff = rtp_pkg::WORD_W'(cap_s1) - rtp_pkg::WORD_W'(first_cap_q) + prod_s1;

	// restoring divide, one quotient bit a step; a zero divisor yields all ones
	assign rem_shift = {rem_q, quo_q[rtp_pkg::WORD_W-1]};
	assign rem_trial = rem_shift - {1'b0, ticks_per_ms_q};
	assign quo_bit   = (rem_shift >= {1'b0, ticks_per_ms_q});

	assign phase_inc  = phase_q + rtp_pkg::OPS_W'(1);
	assign boundary   = (phase_inc >= ovf_per_sec_q);
	assign rounds_inc = rounds_q + rtp_pkg::WORD_W'(1);

	always_comb begin
		sec_nxt  = sec_q + rtp_pkg::SEC_W'(1);
		min_nxt  = min_q;
		hour_nxt = hour_q;
		if (sec_nxt >= rtp_pkg::SEC_WRAP) begin
			sec_nxt = '0;
			min_nxt = min_q + rtp_pkg::MIN_W'(1);
			if (min_nxt >= rtp_pkg::MIN_WRAP) begin
				min_nxt  = '0;
				hour_nxt = hour_q + rtp_pkg::HOUR_W'(1);
				if (hour_nxt >= rtp_pkg::HOUR_WRAP) begin
					hour_nxt = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_period_q <= rtp_pkg::TIMER_PERIOD_RST;
			ticks_per_ms_q <= rtp_pkg::TICKS_PER_MS_RST;
			ovf_per_sec_q  <= rtp_pkg::OVF_PER_SEC_RST;
			warmup_q       <= rtp_pkg::WARMUP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				rtp_pkg::CFG_TIMER_PERIOD: timer_period_q <= cfg_data[rtp_pkg::CAP_W-1:0];
				rtp_pkg::CFG_TICKS_PER_MS: ticks_per_ms_q <= cfg_data[rtp_pkg::TPM_W-1:0];
				rtp_pkg::CFG_OVF_PER_SEC:  ovf_per_sec_q  <= cfg_data[rtp_pkg::OPS_W-1:0];
				rtp_pkg::CFG_WARMUP:       warmup_q       <= cfg_data[rtp_pkg::WARM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovf_cnt_q     <= '0;
			phase_q       <= '0;
			first_taken_q <= 1'b0;
			first_cap_q   <= '0;
			lock_q        <= 1'b0;
			rounds_q      <= '0;
			period_q      <= rtp_pkg::PERIOD_MS_RST;
			secs_q        <= '0;
			hour_q        <= '0;
			min_q         <= '0;
			sec_q         <= '0;
			done_q        <= 1'b0;
			div_cnt_q     <= '0;
		end else begin
			if (cmd.accept) begin
				done_q <= in_action && lock_q;
				if (!in_action) begin
					ovf_cnt_q <= ovf_cnt_q + rtp_pkg::WORD_W'(1);
					phase_q   <= boundary ? '0 : phase_inc;
					if (boundary && lock_q) begin
						secs_q <= secs_q + rtp_pkg::WORD_W'(1);
						sec_q  <= sec_nxt;
						min_q  <= min_nxt;
						hour_q <= hour_nxt;
					end
				end else if (!lock_q) begin
					if (rounds_inc > rtp_pkg::WORD_W'(warmup_q)) begin
						lock_q   <= 1'b1;
						rounds_q <= '0;
					end else begin
						rounds_q <= rounds_inc;
					end
				end else begin
					rounds_q <= rounds_inc;
					if (!first_taken_q) begin
						first_cap_q   <= in_capture_value;
						first_taken_q <= 1'b1;
						ovf_cnt_q     <= '0;
					end
				end
			end
			if (cmd.div_load) begin
				div_cnt_q <= '0;
			end
			if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + rtp_pkg::DIV_CNT_W'(1);
				if (sts.div_last) begin
					period_q      <= {quo_q[rtp_pkg::WORD_W-2:0], quo_bit};
					first_taken_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			prod_s1 <= prod_full[rtp_pkg::WORD_W-1:0];
			cap_s1  <= in_capture_value;
		end
		if (cmd.div_load) begin
			quo_q <= diff;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[rtp_pkg::WORD_W-2:0], quo_bit};
			rem_q <= quo_bit ? rem_trial[rtp_pkg::TPM_W-1:0] : rem_shift[rtp_pkg::TPM_W-1:0];
		end
		if (cmd.out_load) begin
			interval_ms     <= period_q;
			elapsed_seconds <= secs_q;
			clock_hours     <= hour_q;
			clock_minutes   <= min_q;
			clock_seconds   <= sec_q;
			round_done      <= done_q;
			locked          <= lock_q;
			round_count     <= rounds_q;
		end
	end

endmodule
`default_nettype wire

@@ hdl/rotation_period_and_clock_timer.sv @@
// An overflow or a capture that closes no pair goes from acceptance to the output state,
// which waits until the output register is free; a capture that closes a pair goes through
// load, 32 divide steps and output. A new item is taken only after the last has left output.
// The output register lets the next item in while a result waits.
// Reset (arst_n low): configuration back to defaults, counters and clock cleared,
// interval 100 ms, unlocked.
`timescale 1ns / 1ps
`default_nettype none
module rotation_period_and_clock_timer (
	input wire logic clk,
	input wire logic arst_n,
	rtp_in_if.sink   in_ch,
	rtp_out_if.source out_ch,
	rtp_cfg_if.sink  cfg
);

	rtp_pkg::cmd_t cmd;
	rtp_pkg::sts_t sts;

	assign cfg.ready = 1'b1;

	rtp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	rtp_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.cfg_we           (cfg.valid),
		.cfg_index        (cfg.index),
		.cfg_data         (cfg.data),
		.in_action        (in_ch.action),
		.in_capture_value (in_ch.capture_value),
		.interval_ms      (out_ch.interval_ms),
		.elapsed_seconds  (out_ch.elapsed_seconds),
		.clock_hours      (out_ch.clock_hours),
		.clock_minutes    (out_ch.clock_minutes),
		.clock_seconds    (out_ch.clock_seconds),
		.round_done       (out_ch.round_done),
		.locked           (out_ch.locked),
		.round_count      (out_ch.round_count)
	);

	// one item at a time: nothing is taken in the cycle after an acceptance
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> !in_ch.ready)
		else $error("item accepted while previous one still in work");

	a_done_needs_lock: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.round_done |-> out_ch.locked)
		else $error("round reported before lock");

	a_clock_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.clock_seconds < rtp_pkg::SEC_WRAP) &&
			(out_ch.clock_minutes < rtp_pkg::MIN_WRAP) &&
			(out_ch.clock_hours < rtp_pkg::HOUR_WRAP))
		else $error("clock field out of range");

	a_divide_len: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_load |=> cmd.div_step)
		else $error("divider not started after load");

endmodule
`default_nettype wire
